[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the vertex weld clustering block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VWC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VWC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/vwc_pkg.sv]
// ----------------------------------------------------------------------------
// Vertex weld clustering package
// Payload types and fixed field widths shared by the block's files.
// ----------------------------------------------------------------------------
package vwc_pkg;

  localparam int COORD_W  = 24;  // signed Q15.8 coordinate
  localparam int IDX_W    = 16;  // reported vertex index
  localparam int RADIUS_W = 23;  // weld radius register
  localparam int LIMIT_W  = 2 * RADIUS_W;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * COORD_W + 1;
  localparam int SUM_W    = SQ_W + 1;

  typedef logic [RADIUS_W-1:0] vwc_radius_t;

  typedef struct packed {
    logic                       start_mesh;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  pos_z;
  } vwc_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] leader_index;
    logic             is_new_leader;
    logic             store_overflow;
  } vwc_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vwc_pos_t;

  typedef struct packed {
    vwc_pos_t         pos;
    logic [IDX_W-1:0] vertex;
  } vwc_leader_t;

  // One distance test result leaving the distance unit.
  typedef struct packed {
    logic             valid;
    logic             below;
    logic [IDX_W-1:0] vertex;
  } vwc_dist_res_t;

endpackage

[sv/vwc_chan_if.sv]
// ----------------------------------------------------------------------------
// Valid/ready channel
// One request channel carrying a payload of type T.
// ----------------------------------------------------------------------------
interface vwc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/vwc_leader_store.sv]
// ----------------------------------------------------------------------------
// Leader store
// Single-port-write, single-port-read memory of cluster leaders with
// registered read data.
// ----------------------------------------------------------------------------
module vwc_leader_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  vwc_pkg::vwc_leader_t wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output vwc_pkg::vwc_leader_t rd_data,
  output logic                 rd_valid
);
  import vwc_pkg::*;

  vwc_leader_t mem_r [DEPTH];
  vwc_leader_t rd_data_r;
  logic        rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;

endmodule

[sv/vwc_dist_unit.sv]
// ----------------------------------------------------------------------------
// Distance unit
// Four-stage pipeline that tests one leader per cycle: squared distance to
// the current vertex compared against the squared weld radius.
// ----------------------------------------------------------------------------
module vwc_dist_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  vwc_pkg::vwc_pos_t                  pos,
  input  logic [vwc_pkg::LIMIT_W-1:0]        limit,
  input  logic                               leader_valid,
  input  vwc_pkg::vwc_leader_t               leader,
  output vwc_pkg::vwc_dist_res_t             res,
  output logic                               busy
);
  import vwc_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0] tag1_r, tag2_r, tag3_r, tag4_r;

  logic signed [DIFF_W-1:0]   dx_nxt, dy_nxt, dz_nxt;
  logic signed [DIFF_W-1:0]   dx_r, dy_r, dz_r;
  logic signed [2*DIFF_W-1:0] px, py, pz;
  logic [SQ_W-1:0]            sqx_r, sqy_r, sqz_r, sqz3_r;
  logic [SUM_W-1:0]           sxy_nxt, sxy_r, total;
  logic                       below_r;

  // Stage 1: per-axis differences, one bit wider than a coordinate.
  assign dx_nxt = $signed({pos.x[COORD_W-1], pos.x}) -
                  $signed({leader.pos.x[COORD_W-1], leader.pos.x});
  assign dy_nxt = $signed({pos.y[COORD_W-1], pos.y}) -
                  $signed({leader.pos.y[COORD_W-1], leader.pos.y});
  assign dz_nxt = $signed({pos.z[COORD_W-1], pos.z}) -
                  $signed({leader.pos.z[COORD_W-1], leader.pos.z});

  // Stage 2: squares; the result is never negative and fits SQ_W bits.
  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign pz = dz_r * dz_r;

  // Stage 3 and 4: sum of squares, then compare.
  assign sxy_nxt = SUM_W'(sqx_r) + SUM_W'(sqy_r);
  assign total   = sxy_r + SUM_W'(sqz3_r);

  always_ff @(posedge clk) begin
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    dz_r   <= dz_nxt;
    tag1_r <= leader.vertex;
    sqx_r  <= px[SQ_W-1:0];
    sqy_r  <= py[SQ_W-1:0];
    sqz_r  <= pz[SQ_W-1:0];
    tag2_r <= tag1_r;
    sxy_r  <= sxy_nxt;
    sqz3_r <= sqz_r;
    tag3_r <= tag2_r;
    below_r <= (total < SUM_W'(limit));
    tag4_r  <= tag3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= leader_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign res.valid  = v4_r;
  assign res.below  = below_r;
  assign res.vertex = tag4_r;
  assign busy       = v1_r | v2_r | v3_r | v4_r;

endmodule

[sv/vertex_weld_clustering.sv]
// ----------------------------------------------------------------------------
// Vertex weld clustering
// Greedy leader clustering of mesh vertices by squared distance against an
// ordered store of cluster leaders, scanned with one shared distance unit.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                        Handshake
//  --------  ---  ---------------------------------------------  -----------
//  in_chan   in   start_mesh, pos_x, pos_y, pos_z (Q15.8)        valid/ready
//  out_chan  out  leader_index, is_new_leader, store_overflow    valid/ready
//  cfg_chan  in   weld_radius (23 bits)                          valid/ready
//
// The store is read one leader per cycle into the distance unit; the
// registered store read and the unit's four stages lie between each read
// and its result. A hit ends the scan early once the pipeline has drained,
// and the next vertex is taken once the result enters the output register.
// Reset (rst_n, synchronous) empties the store, zeroes vertex numbering and
// the weld radius. The block takes no vertex while one is in work; a stalled
// result sits in the output register and does not block the next vertex
// until that vertex's own result is ready. Config requests are always taken.
// ----------------------------------------------------------------------------
module vertex_weld_clustering #(
  parameter int MAX_LEADERS  = 1024,
  parameter int MAX_VERTICES = 65536
) (
  input  logic      clk,
  input  logic      rst_n,
  vwc_chan_if.sink   in_chan,
  vwc_chan_if.source out_chan,
  vwc_chan_if.sink   cfg_chan
);
  import vwc_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = (MAX_LEADERS > 1) ? $clog2(MAX_LEADERS) : 1;
  localparam int CW = $clog2(MAX_LEADERS + 1);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam logic [CW-1:0] LEADER_CAP  = CW'(MAX_LEADERS);
  localparam logic [VW-1:0] LAST_VERTEX = VW'(MAX_VERTICES - 1);

  // Sequencer: wait for a vertex, scan the store, hand over the result.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } vwc_state_t;

  vwc_state_t     state_r, state_nxt;
  logic [CW-1:0]  leader_count_r, leader_count_nxt;
  logic [CW-1:0]  issue_idx_r, issue_idx_nxt;
  logic [VW-1:0]  vertex_cnt_r, vertex_cnt_nxt;
  logic           hit_r, hit_nxt;
  logic           out_valid_r, out_valid_nxt;
  vwc_radius_t    radius_r, radius_nxt;

  vwc_pos_t         pos_r;
  logic [VW-1:0]    self_r;
  logic [IDX_W-1:0] hit_vertex_r;
  logic [LIMIT_W-1:0] limit_r;
  vwc_out_t         out_data_r;

  logic in_accept, cfg_accept, issue_now, scan_end, out_load;
  logic has_room, make_leader, pipe_busy, dist_busy;
  logic [IDX_W-1:0] self_idx;
  logic [VW-1:0]    self_next;
  vwc_leader_t      wr_leader, rd_leader;
  logic             rd_valid;
  vwc_dist_res_t    dist_res;
  vwc_out_t         result;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_accept      = in_chan.valid && in_chan.ready;
  assign cfg_accept     = cfg_chan.valid && cfg_chan.ready;

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Scan control. Leaders are issued in store order, one per cycle, until a
  // hit is seen or every leader has been issued. Results come back in order,
  // so the first hit that returns is the first matching leader; results that
  // follow it are ignored while the pipeline drains.
  // ---------------------------------------------------------------------------
  assign pipe_busy = rd_valid | dist_busy;
  assign issue_now = (state_r == ST_SCAN) && !hit_r && (issue_idx_r != leader_count_r);
  assign scan_end  = (state_r == ST_SCAN) && (hit_r || (issue_idx_r == leader_count_r)) &&
                     !pipe_busy;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  // The count never exceeds the capacity, so inequality means there is room.
  assign has_room    = (leader_count_r != LEADER_CAP);
  assign make_leader = !hit_r && has_room;

  // Vertex numbers wrap to zero after the last one; only the low bits go out.
  assign self_idx  = IDX_W'(self_r);
  assign self_next = (self_r == LAST_VERTEX) ? '0 : self_r + VW'(1);

  assign result.leader_index   = hit_r ? hit_vertex_r : self_idx;
  assign result.is_new_leader  = make_leader;
  assign result.store_overflow = !hit_r && !has_room;

  assign wr_leader.pos    = pos_r;
  assign wr_leader.vertex = self_idx;

  always_comb begin
    state_nxt        = state_r;
    leader_count_nxt = leader_count_r;
    issue_idx_nxt    = issue_idx_r;
    vertex_cnt_nxt   = vertex_cnt_r;
    hit_nxt          = hit_r;
    out_valid_nxt    = out_valid_r;
    radius_nxt       = radius_r;

    if (cfg_accept) begin
      radius_nxt = cfg_chan.data;
    end

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          issue_idx_nxt = '0;
          hit_nxt       = 1'b0;
          // A start flag empties the store before this vertex is tested.
          if (in_chan.data.start_mesh) begin
            leader_count_nxt = '0;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_now) begin
          issue_idx_nxt = issue_idx_r + CW'(1);
        end
        if (dist_res.valid && dist_res.below && !hit_r) begin
          hit_nxt = 1'b1;
        end
        if (scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          vertex_cnt_nxt = self_next;
          if (make_leader) begin
            leader_count_nxt = leader_count_r + CW'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      leader_count_r <= '0;
      issue_idx_r    <= '0;
      vertex_cnt_r   <= '0;
      hit_r          <= 1'b0;
      out_valid_r    <= 1'b0;
      radius_r       <= '0;
    end else begin
      state_r        <= state_nxt;
      leader_count_r <= leader_count_nxt;
      issue_idx_r    <= issue_idx_nxt;
      vertex_cnt_r   <= vertex_cnt_nxt;
      hit_r          <= hit_nxt;
      out_valid_r    <= out_valid_nxt;
      radius_r       <= radius_nxt;
    end
  end

  // Payload registers. The squared radius is refreshed every cycle; it is
  // first used in the distance unit's compare, behind the store read.
  always_ff @(posedge clk) begin
    limit_r <= LIMIT_W'(radius_r) * LIMIT_W'(radius_r);
    if (in_accept) begin
      pos_r.x <= in_chan.data.pos_x;
      pos_r.y <= in_chan.data.pos_y;
      pos_r.z <= in_chan.data.pos_z;
      self_r  <= in_chan.data.start_mesh ? '0 : vertex_cnt_r;
    end
    if ((state_r == ST_SCAN) && dist_res.valid && dist_res.below && !hit_r) begin
      hit_vertex_r <= dist_res.vertex;
    end
    if (out_load) begin
      out_data_r <= result;
    end
  end

  // ---------------------------------------------------------------------------
  // Leader store and shared distance unit
  // ---------------------------------------------------------------------------
  vwc_leader_store #(
    .DEPTH (MAX_LEADERS),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (out_load && make_leader),
    .wr_addr  (leader_count_r[AW-1:0]),
    .wr_data  (wr_leader),
    .rd_en    (issue_now),
    .rd_addr  (issue_idx_r[AW-1:0]),
    .rd_data  (rd_leader),
    .rd_valid (rd_valid)
  );

  vwc_dist_unit u_dist (
    .clk          (clk),
    .rst_n        (rst_n),
    .pos          (pos_r),
    .limit        (limit_r),
    .leader_valid (rd_valid),
    .leader       (rd_leader),
    .res          (dist_res),
    .busy         (dist_busy)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `VWC_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, leader_count_r <= LEADER_CAP, "leader count above capacity")
  `VWC_ASSERT_IMP(a_done_drained, clk, rst_n, state_r == ST_DONE, !pipe_busy, "result formed with tests in flight")
  `VWC_ASSERT_NEXT(a_leader_added, clk, rst_n, out_load && make_leader, leader_count_r == $past(leader_count_r) + CW'(1), "new leader not counted")
  `VWC_ASSERT_IMP(a_flags_exclusive, clk, rst_n, out_valid_r, !(out_data_r.is_new_leader && out_data_r.store_overflow), "new leader and overflow together")
  `VWC_ASSERT_NEXT(a_start_clears, clk, rst_n, in_accept && in_chan.data.start_mesh, leader_count_r == '0 && issue_idx_r == '0, "start did not empty the store")

endmodule

[tb/sv/vertex_weld_clustering_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex weld clustering testbench
// Drives vertex requests and weld radius writes into the clustering block.
// A scoreboard keeps its own leader store and vertex numbering and predicts
// each result. Every accepted result is checked in order against it. Sender
// bursts and receiver stall patterns vary the timing of the handshakes.
// ----------------------------------------------------------------------------
module vertex_weld_clustering_tb;
  import vwc_pkg::*;

  localparam int TB_MAX_LEADERS  = 1024;
  localparam int TB_MAX_VERTICES = 65536;

  localparam int          COORD_MAX  = 8388607;
  localparam int          COORD_MIN  = -8388608;
  localparam vwc_radius_t RADIUS_MAX = '1;

  // Number of random vertex requests after the directed part.
  localparam int RANDOM_VERTICES = 565;

  // Cycles allowed after the last result for anything stray to show up.
  localparam int SETTLE_CYCLES = 40;

  // Up to 619 vertices go in, so the store never holds more than that many
  // leaders and no scan runs past that bound. Sender gaps and receiver stalls
  // add little on top, so the slowest correct run stays under this limit.
  localparam longint CYCLE_LIMIT = 2_000_000;

  // Predicts the block's result for every accepted vertex and checks the
  // results in the order they come back.
  class weld_scoreboard;
    vwc_pos_t         leader_pos[TB_MAX_LEADERS];
    logic [IDX_W-1:0] leader_id[TB_MAX_LEADERS];
    int unsigned      leader_total;
    int unsigned      vertex_number;
    vwc_radius_t      radius;
    vwc_out_t         expected_q[$];
    int unsigned      result_count;
    int unsigned      error_count;

    function new();
      leader_total  = 0;
      vertex_number = 0;
      radius        = '0;
      result_count  = 0;
      error_count   = 0;
    endfunction

    function void set_radius(vwc_radius_t r);
      radius = r;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void report_error(string msg);
      error_count++;
      if (error_count <= 10) begin
        $display("[%0t] ERROR: %s", $realtime, msg);
      end
    endfunction

    // Greedy leader search: the first stored leader strictly inside the
    // radius claims the vertex; otherwise it becomes a leader if there is room.
    function void note_vertex(vwc_in_t v);
      longint      limit;
      longint      dx;
      longint      dy;
      longint      dz;
      bit          claimed;
      int unsigned self_id;
      vwc_out_t    e;
      vwc_pos_t    p;

      limit = longint'(radius) * longint'(radius);
      if (v.start_mesh) begin
        leader_total  = 0;
        vertex_number = 0;
      end
      self_id          = vertex_number;
      claimed          = 1'b0;
      e.leader_index   = self_id[IDX_W-1:0];
      e.is_new_leader  = 1'b0;
      e.store_overflow = 1'b0;
      p.x = v.pos_x;
      p.y = v.pos_y;
      p.z = v.pos_z;

      for (int i = 0; i < leader_total; i++) begin
        dx = longint'($signed(v.pos_x)) - longint'($signed(leader_pos[i].x));
        dy = longint'($signed(v.pos_y)) - longint'($signed(leader_pos[i].y));
        dz = longint'($signed(v.pos_z)) - longint'($signed(leader_pos[i].z));
        if (dx * dx + dy * dy + dz * dz < limit) begin
          claimed        = 1'b1;
          e.leader_index = leader_id[i];
          break;
        end
      end

      if (!claimed) begin
        if (leader_total < TB_MAX_LEADERS) begin
          leader_pos[leader_total] = p;
          leader_id[leader_total]  = self_id[IDX_W-1:0];
          leader_total++;
          e.is_new_leader = 1'b1;
        end else begin
          e.store_overflow = 1'b1;
        end
      end

      vertex_number = (self_id + 1) % TB_MAX_VERTICES;
      expected_q = {expected_q, e};
    endfunction

    function void check_result(vwc_out_t got);
      vwc_out_t e;

      result_count++;
      if (expected_q.size() == 0) begin
        report_error($sformatf("result %0d arrived with no vertex pending: index %0d",
                               result_count, got.leader_index));
        return;
      end
      e = expected_q.pop_front();
      if (got.leader_index !== e.leader_index ||
          got.is_new_leader !== e.is_new_leader ||
          got.store_overflow !== e.store_overflow) begin
        report_error($sformatf(
          "result %0d: expected index %0d new %0b overflow %0b, got index %0d new %0b overflow %0b",
          result_count, e.leader_index, e.is_new_leader, e.store_overflow,
          got.leader_index, got.is_new_leader, got.store_overflow));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  vwc_chan_if #(.T(vwc_in_t))     in_chan  ();
  vwc_chan_if #(.T(vwc_out_t))    out_chan ();
  vwc_chan_if #(.T(vwc_radius_t)) cfg_chan ();

  vertex_weld_clustering #(
    .MAX_LEADERS  (TB_MAX_LEADERS),
    .MAX_VERTICES (TB_MAX_VERTICES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  weld_scoreboard weld_sb;

  // Pacing controls. The sender works in bursts separated by random gaps when
  // pace_sender is set; the receiver follows its stall pattern unless
  // hold_ready_high forces it to take every result.
  bit          pace_sender;
  bit          hold_ready_high;
  int unsigned burst_left;
  logic [15:0] ready_pattern;
  logic [3:0]  pattern_phase;
  longint      cycle_count;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Receiver: steps bit by bit through a 16-bit ready pattern and draws a new one at
  // the end of each pass. Some patterns never stall, some stall at random and
  // one holds ready low for most of the pass to back results up.
  always @(posedge clk) begin
    if (hold_ready_high) begin
      out_chan.ready <= 1'b1;
    end else begin
      out_chan.ready <= ready_pattern[pattern_phase];
    end
    if (pattern_phase == 4'd15) begin
      case ($urandom_range(0, 4))
        0: begin
          ready_pattern <= 16'hFFFF;
        end
        1: begin
          ready_pattern <= 16'($urandom);
        end
        2: begin
          ready_pattern <= 16'($urandom | $urandom);
        end
        3: begin
          ready_pattern <= 16'h8000;
        end
        default: begin
          ready_pattern <= 16'hF0F0;
        end
      endcase
    end
    pattern_phase <= pattern_phase + 4'd1;
  end

  // Every accepted result request is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      weld_sb.check_result(out_chan.data);
    end
  end

  // Watchdog: a run that hangs on a handshake ends here as a failure.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic vwc_in_t make_vertex(bit start, int x, int y, int z);
    vwc_in_t v;

    v.start_mesh = start;
    v.pos_x      = x[COORD_W-1:0];
    v.pos_y      = y[COORD_W-1:0];
    v.pos_z      = z[COORD_W-1:0];
    return v;
  endfunction

  // Drops valid while the sender idles. With n of zero valid is left alone, so a
  // back-to-back request keeps valid high without a second assignment.
  task automatic idle_sender(int unsigned n);
    if (n > 0) begin
      in_chan.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offers one vertex request and returns at the edge where it is taken.
  // The prediction is made right there, so it is in place before any later
  // check in this process looks at the pending count.
  task automatic push_vertex(vwc_in_t v);
    if (pace_sender) begin
      if (burst_left == 0) begin
        idle_sender($urandom_range(0, 12));
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= v;
    do @(posedge clk); while (!in_chan.ready);
    weld_sb.note_vertex(v);
  endtask

  // Waits until every predicted result has come back. Each vertex produces
  // exactly one result, so an empty queue means the block is idle.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    while (weld_sb.pending() != 0) @(posedge clk);
  endtask

  // The radius is only changed with the block idle.
  task automatic write_radius(vwc_radius_t r);
    drain_results();
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= r;
    do @(posedge clk); while (!cfg_chan.ready);
    weld_sb.set_radius(r);
    cfg_chan.valid <= 1'b0;
  endtask

  initial begin
    vwc_pos_t    mesh_pts[$];
    vwc_pos_t    base;
    vwc_radius_t r;
    int          span;
    int          x;
    int          y;
    int          z;
    int unsigned sel;
    int unsigned mesh_len;
    int unsigned sent;
    bit          start;

    // Everything the testbench drives is known from time zero.
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.data    = '0;
    cfg_chan.valid  = 1'b0;
    cfg_chan.data   = '0;
    out_chan.ready  = 1'b0;
    ready_pattern   = 16'hFFFF;
    pattern_phase   = '0;
    cycle_count     = 0;
    pace_sender     = 1'b1;
    hold_ready_high = 1'b0;
    burst_left      = 0;
    weld_sb         = new();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // ---- Directed part ----
    // The radius still holds its reset value of zero here: nothing is
    // strictly closer than zero, so every vertex must found a new cluster,
    // even one sitting exactly on an existing leader.
    push_vertex(make_vertex(1'b1, 0, 0, 0));
    push_vertex(make_vertex(1'b0, COORD_MAX, COORD_MAX, COORD_MAX));
    push_vertex(make_vertex(1'b0, COORD_MIN, COORD_MIN, COORD_MIN));
    push_vertex(make_vertex(1'b0, 0, 0, 0));

    // Radius one: only an exact duplicate welds; one unit away is on the
    // boundary and must not.
    write_radius(vwc_radius_t'(1));
    push_vertex(make_vertex(1'b0, 0, 0, 0));
    push_vertex(make_vertex(1'b0, 1, 0, 0));

    // Largest radius. A corner vertex finds its twin leader. A vertex exactly
    // one radius from the first leader is not claimed by it but by the later
    // leader one unit closer, which checks both the strict compare and the
    // store order. Two opposite extremes on separate axes stay out of reach.
    write_radius(RADIUS_MAX);
    push_vertex(make_vertex(1'b0, COORD_MIN, COORD_MIN, COORD_MIN));
    push_vertex(make_vertex(1'b0, COORD_MAX, 0, 0));
    push_vertex(make_vertex(1'b0, 0, COORD_MAX, COORD_MIN));
    push_vertex(make_vertex(1'b0, 5, -7, 3));

    // Two starts in a row, the first on a vertex with nonzero coordinates:
    // each clears the store before its own vertex is numbered.
    push_vertex(make_vertex(1'b1, -1, -1, -1));
    push_vertex(make_vertex(1'b1, COORD_MAX, COORD_MIN, 0));
    push_vertex(make_vertex(1'b0, COORD_MAX, COORD_MIN, 1));

    // A mid-range radius with one vertex just inside and one exactly on it.
    write_radius(vwc_radius_t'(1000));
    push_vertex(make_vertex(1'b0, COORD_MAX - 999, COORD_MIN, 1));
    push_vertex(make_vertex(1'b0, COORD_MAX - 1000, COORD_MIN, 0));

    // ---- Random part ----
    // Most of the traffic is meshes: a start request followed by vertices,
    // many of them jittered copies of earlier ones so that welding happens
    // around the radius. Occasional meshes carry on without a start, and
    // occasional stray start flags break a mesh in the middle. Some vertices
    // are drawn over the whole coordinate range.
    sent = 0;
    while (sent < RANDOM_VERTICES) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0: begin
            r = '0;
          end
          1: begin
            r = RADIUS_MAX;
          end
          2: begin
            r = vwc_radius_t'($urandom_range(1, 16));
          end
          3: begin
            r = vwc_radius_t'($urandom_range(1, 4096));
          end
          4: begin
            r = vwc_radius_t'($urandom_range(4096, 1 << 20));
          end
          default: begin
            r = vwc_radius_t'($urandom);
          end
        endcase
        write_radius(r);
      end

      mesh_len = $urandom_range(1, 40);
      mesh_pts.delete();
      span = (weld_sb.radius == 0) ? 2 : int'(weld_sb.radius);
      for (int j = 0; j < mesh_len; j++) begin
        if (j == 0) begin
          start = ($urandom_range(0, 7) != 0);
        end else begin
          start = ($urandom_range(0, 29) == 0);
        end
        sel = $urandom_range(0, 9);
        if (sel < 5 && mesh_pts.size() > 0) begin
          base = mesh_pts[$urandom_range(0, mesh_pts.size() - 1)];
          if (sel == 0) begin
            x = $signed(base.x);
            y = $signed(base.y);
            z = $signed(base.z);
          end else begin
            x = $signed(base.x) + $urandom_range(0, 2 * span) - span;
            y = $signed(base.y) + $urandom_range(0, 2 * span) - span;
            z = $signed(base.z) + $urandom_range(0, 2 * span) - span;
          end
        end else if (sel < 8) begin
          x = $urandom_range(0, 8191) - 4096;
          y = $urandom_range(0, 8191) - 4096;
          z = $urandom_range(0, 8191) - 4096;
        end else begin
          x = int'($urandom);
          y = int'($urandom);
          z = int'($urandom);
        end
        push_vertex(make_vertex(start, x, y, z));
        base.x = x[COORD_W-1:0];
        base.y = y[COORD_W-1:0];
        base.z = z[COORD_W-1:0];
        mesh_pts = {mesh_pts, base};
        sent++;
      end
    end

    // ---- End of run ----
    in_chan.valid <= 1'b0;
    while (weld_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (weld_sb.error_count == 0 && weld_sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/vwc_pkg.sv
sv/vwc_chan_if.sv
sv/vwc_leader_store.sv
sv/vwc_dist_unit.sv
sv/vertex_weld_clustering.sv
tb/sv/vertex_weld_clustering_tb.sv
